// ----- rtl/qsmv_pkg.sv -----
// Package for the quasi-stationary matrix-vector unit.
// Holds payload and control structs, action, region and configuration index codes and size constants.
// No dependencies.
`timescale 1ns / 1ps

package qsmv_pkg;

  localparam int MAX_ROWS   = 1024;
  localparam int MAX_CORNER = 8;
  localparam int MAX_BAND   = 16;
  localparam int VALUE_BITS = 24;
  localparam int COEF_BITS  = 18;
  localparam int FRAC       = 16;
  localparam int ACC_BITS   = 48;

  localparam logic [2:0] ACT_LCORNER = 3'd0;
  localparam logic [2:0] ACT_RCORNER = 3'd1;
  localparam logic [2:0] ACT_LBAND   = 3'd2;
  localparam logic [2:0] ACT_RBAND   = 3'd3;
  localparam logic [2:0] ACT_CLEAR   = 3'd4;
  localparam logic [2:0] ACT_XELEM   = 3'd5;
  localparam logic [2:0] ACT_READ    = 3'd6;

  localparam logic [1:0] REG_LCORNER = 2'd0;
  localparam logic [1:0] REG_LBAND   = 2'd1;
  localparam logic [1:0] REG_RBAND   = 2'd2;
  localparam logic [1:0] REG_RCORNER = 2'd3;

  localparam logic [2:0] CFG_ROW_COUNT   = 3'd0;
  localparam logic [2:0] CFG_COL_COUNT   = 3'd1;
  localparam logic [2:0] CFG_CORNER_DIMS = 3'd2;
  localparam logic [2:0] CFG_BAND_GEOM   = 3'd3;
  localparam logic [2:0] CFG_SCALE       = 3'd4;
  localparam logic [2:0] CFG_INPUT_BASE  = 3'd5;
  localparam logic [2:0] CFG_OUTPUT_BASE = 3'd6;

  typedef struct packed {
    logic [2:0]                    action;
    logic [9:0]                    row_index;
    logic [15:0]                   col_index;
    logic signed [VALUE_BITS-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [15:0]                   position;
    logic signed [VALUE_BITS-1:0]  result_value;
    logic                          saturated;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       clr_we;
    logic       coef_rd;
    logic       mac_we;
    logic       out_load;
    logic [1:0] region;
    logic [4:0] k;
  } qsmv_cmd_t;

  typedef struct packed {
    logic       reg_active;
    logic [4:0] reg_count;
    logic       clr_done;
    logic       out_free;
  } qsmv_status_t;

endpackage

// ----- rtl/qsmv_ctrl.sv -----
// Controller state machine of the quasi-stationary matrix-vector unit.
// Sequences clears, per-row multiply-accumulates and reads; uses qsmv_pkg.
`timescale 1ns / 1ps

module qsmv_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [2:0]              in_action_i,
  output logic                    in_stall_o,
  input  qsmv_pkg::qsmv_status_t  status_i,
  output qsmv_pkg::qsmv_cmd_t     cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CLEAR   = 4'd1;
  localparam logic [3:0] S_REGION  = 4'd2;
  localparam logic [3:0] S_COEF    = 4'd3;
  localparam logic [3:0] S_MUL1    = 4'd4;
  localparam logic [3:0] S_MUL2    = 4'd5;
  localparam logic [3:0] S_ACC     = 4'd6;
  localparam logic [3:0] S_RD_WAIT = 4'd7;
  localparam logic [3:0] S_RD_OUT  = 4'd8;

  logic [3:0] state_q, state_d;
  logic [1:0] region_q, region_d;
  logic [4:0] k_q, k_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    region_d = region_q;
    k_d      = k_q;
    cmd_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          priority case (in_action_i)
            qsmv_pkg::ACT_CLEAR: state_d = S_CLEAR;
            qsmv_pkg::ACT_XELEM: begin
              region_d = qsmv_pkg::REG_LCORNER;
              state_d  = S_REGION;
            end
            qsmv_pkg::ACT_READ: state_d = S_RD_WAIT;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (status_i.clr_done) state_d = S_IDLE;
      end
      S_REGION: begin
        if (status_i.reg_active && status_i.reg_count != 5'd0) begin
          k_d     = 5'd0;
          state_d = S_COEF;
        end else if (region_q == qsmv_pkg::REG_RCORNER) begin
          state_d = S_IDLE;
        end else begin
          region_d = region_q + 2'd1;
        end
      end
      S_COEF: begin
        cmd_o.coef_rd = 1'b1;
        state_d       = S_MUL1;
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_ACC;
      S_ACC: begin
        cmd_o.mac_we = 1'b1;
        if (k_q + 5'd1 == status_i.reg_count) begin
          if (region_q == qsmv_pkg::REG_RCORNER) begin
            state_d = S_IDLE;
          end else begin
            region_d = region_q + 2'd1;
            state_d  = S_REGION;
          end
        end else begin
          k_d     = k_q + 5'd1;
          state_d = S_COEF;
        end
      end
      S_RD_WAIT: state_d = S_RD_OUT;
      S_RD_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    cmd_o.region = region_q;
    cmd_o.k      = k_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      region_q <= 2'd0;
      k_q      <= 5'd0;
    end else begin
      state_q  <= state_d;
      region_q <= region_d;
      k_q      <= k_d;
    end
  end

endmodule

// ----- rtl/qsmv_datapath.sv -----
// Datapath of the quasi-stationary matrix-vector unit: configuration registers,
// coefficient stores, accumulator memory, multipliers and output register; uses qsmv_pkg.
`timescale 1ns / 1ps

module qsmv_datapath #(
  parameter int MAX_ROWS = qsmv_pkg::MAX_ROWS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic [2:0]              cfg_index_i,
  input  logic [31:0]             cfg_data_i,
  input  qsmv_pkg::in_item_t      in_data_i,
  input  qsmv_pkg::qsmv_cmd_t     cmd_i,
  output qsmv_pkg::qsmv_status_t  status_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output qsmv_pkg::out_item_t     out_data_o
);

  localparam int AW   = $clog2(MAX_ROWS);
  localparam int MC   = qsmv_pkg::MAX_CORNER;
  localparam int MB   = qsmv_pkg::MAX_BAND;
  localparam int CW   = $clog2(MC);
  localparam int CAW  = $clog2(MC * MC);
  localparam int BAW  = $clog2(MB);
  localparam int CB   = qsmv_pkg::COEF_BITS;
  localparam int VB   = qsmv_pkg::VALUE_BITS;
  localparam int FR   = qsmv_pkg::FRAC;
  localparam int ABW  = qsmv_pkg::ACC_BITS;
  localparam int P1W  = 2 * CB;
  localparam int KW   = P1W + 1 - FR;
  localparam int TW   = KW + VB;

  // Configuration registers.
  logic [10:0]          row_count_q, col_count_q;
  logic [15:0]          corner_dims_q;
  logic [25:0]          band_geom_q;
  logic signed [17:0]   scale_q;
  logic [15:0]          input_base_q, output_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q   <= '0;
      col_count_q   <= '0;
      corner_dims_q <= '0;
      band_geom_q   <= '0;
      scale_q       <= 18'sd65536;
      input_base_q  <= '0;
      output_base_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        qsmv_pkg::CFG_ROW_COUNT:   row_count_q   <= cfg_data_i[10:0];
        qsmv_pkg::CFG_COL_COUNT:   col_count_q   <= cfg_data_i[10:0];
        qsmv_pkg::CFG_CORNER_DIMS: corner_dims_q <= cfg_data_i[15:0];
        qsmv_pkg::CFG_BAND_GEOM:   band_geom_q   <= cfg_data_i[25:0];
        qsmv_pkg::CFG_SCALE:       scale_q       <= cfg_data_i[17:0];
        qsmv_pkg::CFG_INPUT_BASE:  input_base_q  <= cfg_data_i[15:0];
        qsmv_pkg::CFG_OUTPUT_BASE: output_base_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Latched item.
  qsmv_pkg::in_item_t item_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
  end

  // Clamped geometry.
  logic [3:0] ml, nl, mr, nr;
  logic [4:0] lenl, lenr;
  assign ml   = (corner_dims_q[3:0]   > 4'(MC)) ? 4'(MC) : corner_dims_q[3:0];
  assign nl   = (corner_dims_q[7:4]   > 4'(MC)) ? 4'(MC) : corner_dims_q[7:4];
  assign mr   = (corner_dims_q[11:8]  > 4'(MC)) ? 4'(MC) : corner_dims_q[11:8];
  assign nr   = (corner_dims_q[15:12] > 4'(MC)) ? 4'(MC) : corner_dims_q[15:12];
  assign lenl = (band_geom_q[4:0] > 5'(MB)) ? 5'(MB) : band_geom_q[4:0];
  assign lenr = (band_geom_q[9:5] > 5'(MB)) ? 5'(MB) : band_geom_q[9:5];

  logic [16:0]        m_u;
  logic signed [17:0] m_s, n_s, n2_s, nlr_s, c_s, ccol_s, nl_s;
  logic signed [17:0] start_s, row_s;
  logic [16:0]        cdiff;
  logic               x_valid;

  assign m_u    = ({6'd0, row_count_q} > 17'(MAX_ROWS)) ? 17'(MAX_ROWS)
                                                        : {6'd0, row_count_q};
  assign m_s    = 18'(m_u);
  assign n_s    = 18'(col_count_q);
  assign n2_s   = 18'(col_count_q >> 1);
  assign nl_s   = 18'(nl);
  assign nlr_s  = n_s - 18'(nr);
  assign cdiff  = {1'b0, item_q.col_index} - {1'b0, input_base_q};
  assign x_valid = (item_q.col_index >= input_base_q) && (cdiff[15:0] < {5'd0, col_count_q});
  assign c_s    = 18'(cdiff[15:0]);
  assign ccol_s = c_s - nlr_s;

  always_comb begin
    status_o.reg_active = 1'b0;
    status_o.reg_count  = 5'd0;
    start_s             = '0;
    unique case (cmd_i.region)
      qsmv_pkg::REG_LCORNER: begin
        status_o.reg_active = c_s < nl_s;
        status_o.reg_count  = 5'(ml);
      end
      qsmv_pkg::REG_LBAND: begin
        status_o.reg_active = (c_s >= nl_s) && (c_s < n2_s);
        status_o.reg_count  = lenl;
        start_s = 18'(band_geom_q[17:10]) + ((c_s - nl_s) <<< 1);
      end
      qsmv_pkg::REG_RBAND: begin
        status_o.reg_active = (c_s >= n2_s) && (c_s < nlr_s);
        status_o.reg_count  = lenr;
        start_s = m_s - 18'(band_geom_q[25:18]) - ((nlr_s - 18'sd1 - c_s) <<< 1)
                  - 18'(lenr);
      end
      qsmv_pkg::REG_RCORNER: begin
        status_o.reg_active = (c_s >= nlr_s) && (ccol_s < 18'(MC));
        status_o.reg_count  = 5'(mr);
        start_s = m_s - 18'(mr);
      end
      default: ;
    endcase
    status_o.reg_active = status_o.reg_active && x_valid;
  end
  assign row_s = start_s + 18'(cmd_i.k);

  // Coefficient stores, written on load beats and read with a registered port.
  logic signed [CB-1:0] lc_mem [MC*MC];
  logic signed [CB-1:0] rc_mem [MC*MC];
  logic signed [CB-1:0] lb_mem [MB];
  logic signed [CB-1:0] rb_mem [MB];
  logic signed [CB-1:0] lc_rd_q, rc_rd_q, lb_rd_q, rb_rd_q;
  logic [CAW-1:0]       cw_addr, lc_raddr, rc_raddr;
  logic                 corner_ok, band_ok;
  logic signed [CB-1:0] coef_in;

  assign coef_in   = in_data_i.value[CB-1:0];
  assign corner_ok = ({6'd0, in_data_i.row_index} < 16'(MC)) && (in_data_i.col_index < 16'(MC));
  assign band_ok   = in_data_i.col_index < 16'(MB);
  assign cw_addr   = CAW'(int'(in_data_i.row_index[CW-1:0]) * MC
                          + int'(in_data_i.col_index[CW-1:0]));
  assign lc_raddr  = CAW'(int'(cmd_i.k[CW-1:0]) * MC + int'(c_s[CW-1:0]));
  assign rc_raddr  = CAW'(int'(cmd_i.k[CW-1:0]) * MC + int'(ccol_s[CW-1:0]));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && corner_ok && in_data_i.action == qsmv_pkg::ACT_LCORNER)
      lc_mem[cw_addr] <= coef_in;
    lc_rd_q <= lc_mem[lc_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && corner_ok && in_data_i.action == qsmv_pkg::ACT_RCORNER)
      rc_mem[cw_addr] <= coef_in;
    rc_rd_q <= rc_mem[rc_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && band_ok && in_data_i.action == qsmv_pkg::ACT_LBAND)
      lb_mem[in_data_i.col_index[BAW-1:0]] <= coef_in;
    lb_rd_q <= lb_mem[cmd_i.k[BAW-1:0]];
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && band_ok && in_data_i.action == qsmv_pkg::ACT_RBAND)
      rb_mem[in_data_i.col_index[BAW-1:0]] <= coef_in;
    rb_rd_q <= rb_mem[cmd_i.k[BAW-1:0]];
  end

  logic signed [CB-1:0] coef_sel;
  always_comb begin
    unique case (cmd_i.region)
      qsmv_pkg::REG_LCORNER: coef_sel = lc_rd_q;
      qsmv_pkg::REG_LBAND:   coef_sel = lb_rd_q;
      qsmv_pkg::REG_RBAND:   coef_sel = rb_rd_q;
      default:               coef_sel = rc_rd_q;
    endcase
  end

  // Target row of the current beat, set on a load (reads) or per coefficient step.
  logic signed [17:0] row_q;
  logic               inr_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_q <= 18'(in_data_i.row_index);
      inr_q <= {6'd0, in_data_i.row_index} < 16'(MAX_ROWS);
    end else if (cmd_i.coef_rd) begin
      row_q <= row_s;
      inr_q <= (row_s >= 18'sd0) && (row_s < m_s);
    end
  end

  // Two multiplier stages: coefficient times scale, then rounded factor times x.
  logic signed [P1W-1:0] p1_q;
  logic signed [P1W:0]   p1_rnd;
  logic signed [KW-1:0]  kf;
  logic signed [TW-1:0]  term_q;
  assign p1_rnd = (P1W+1)'(p1_q) + (P1W+1)'(1 <<< (FR - 1));
  assign kf     = KW'(p1_rnd >>> FR);
  always_ff @(posedge clk_i) begin
    p1_q   <= coef_sel * scale_q;
    term_q <= kf * item_q.value;
  end

  // Accumulator memory.
  logic signed [ABW-1:0] acc_mem [MAX_ROWS];
  logic signed [ABW-1:0] acc_rd_q, acc_new;
  logic signed [ABW:0]   acc_sum;
  logic [AW-1:0]         clr_addr_q;
  localparam logic signed [ABW-1:0] ACC_MAX = {1'b0, {(ABW-1){1'b1}}};
  localparam logic signed [ABW-1:0] ACC_MIN = {1'b1, {(ABW-1){1'b0}}};

  assign acc_sum = (ABW+1)'(acc_rd_q) + (ABW+1)'(term_q);
  always_comb begin
    if (acc_sum[ABW] != acc_sum[ABW-1]) acc_new = acc_sum[ABW] ? ACC_MIN : ACC_MAX;
    else                                acc_new = acc_sum[ABW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_we)               acc_mem[clr_addr_q]    <= '0;
    else if (cmd_i.mac_we && inr_q) acc_mem[row_q[AW-1:0]] <= acc_new;
    acc_rd_q <= acc_mem[row_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)           clr_addr_q <= '0;
    else if (cmd_i.load)   clr_addr_q <= '0;
    else if (cmd_i.clr_we) clr_addr_q <= clr_addr_q + AW'(1);
  end
  assign status_o.clr_done = (clr_addr_q == AW'(MAX_ROWS - 1));

  // Read rounding and saturation to the result format.
  localparam int RW = ABW + 1 - FR;
  logic signed [ABW:0]   rd_rnd;
  logic signed [RW-1:0]  rd_r;
  logic signed [VB-1:0]  rd_val;
  logic                  rd_sat;
  localparam logic signed [RW-1:0] VMAX = RW'((64'sd1 <<< (VB - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] VMIN = -VMAX - RW'(1);
  assign rd_rnd = (ABW+1)'(acc_rd_q) + (ABW+1)'(1 <<< (FR - 1));
  assign rd_r   = RW'(rd_rnd >>> FR);
  always_comb begin
    rd_sat = 1'b0;
    rd_val = rd_r[VB-1:0];
    if (!inr_q) begin
      rd_val = '0;
    end else if (rd_r > VMAX) begin
      rd_sat = 1'b1;
      rd_val = VMAX[VB-1:0];
    end else if (rd_r < VMIN) begin
      rd_sat = 1'b1;
      rd_val = VMIN[VB-1:0];
    end
  end

  // Output register; the next item may be taken while a beat waits here.
  logic                 out_valid_q;
  qsmv_pkg::out_item_t  out_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)             out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (!out_stall_i)   out_valid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.position     <= output_base_q + 16'(item_q.row_index);
      out_q.result_value <= rd_val;
      out_q.saturated    <= rd_sat;
    end
  end
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/quasi_stationary_matvec_unit.sv -----
// Top level of the quasi-stationary matrix-vector unit.
// Instantiates qsmv_ctrl and qsmv_datapath; uses qsmv_pkg.
`timescale 1ns / 1ps

// Scatter-form banded wavelet matrix times vector, one item at a time. A
// coefficient load leaves the block idle, ready for the next item. An x element
// is taken, then visits each of the four column regions whether it falls into
// it or not, and for each touched row runs a chain of four steps: coefficient
// read, coefficient-by-scale multiply, factor-by-x multiply and the
// read-modify-write of the accumulator memory. A read registers the accumulator
// word and then waits only if the output register still holds an untaken beat.
// A clear sweeps the accumulator memory one row a cycle, while no item is
// accepted. Configuration writes are always ready.

module quasi_stationary_matvec_unit #(
  parameter int MAX_ROWS = qsmv_pkg::MAX_ROWS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  qsmv_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output qsmv_pkg::out_item_t out_data_o
);

  qsmv_pkg::qsmv_cmd_t    cmd;
  qsmv_pkg::qsmv_status_t status;

  assign cfg_ready_o = 1'b1;

  qsmv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_data_i.action),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  qsmv_datapath #(
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A read beat keeps the block busy until its result is registered.
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.action == qsmv_pkg::ACT_READ) |=> in_stall_o)
    else $error("read beat did not occupy the block");

  // A clear beat starts a sweep that blocks further items.
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.action == qsmv_pkg::ACT_CLEAR) |=> in_stall_o)
    else $error("clear beat did not start a sweep");

  // A new result only appears at the end of a read, while the block is busy.
  a_out_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a read in progress");

  // A coefficient load never keeps the block busy.
  a_coef_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.action[2] == 1'b0) |=> !in_stall_o)
    else $error("coefficient load stalled the input");

endmodule
